// ===== src/pcb_pkg.sv =====
// shared types and constants for the pixel convert and blend pipeline
`default_nettype none
package pcb_pkg;

	localparam logic [1:0] FMT_1        = 2'd0;
	localparam logic [1:0] FMT_8        = 2'd1;
	localparam logic [1:0] FMT_32       = 2'd2;
	localparam logic [1:0] FMT_RESERVED = 2'd3;

	localparam logic [1:0] HINT_GENERAL   = 2'd0;
	localparam logic [1:0] HINT_OPAQUE    = 2'd1;
	localparam logic [1:0] HINT_ZEROALPHA = 2'd2;

	localparam logic [2:0] REG_DEST_FORMAT     = 3'd0;
	localparam logic [2:0] REG_SOURCE_FORMAT   = 3'd1;
	localparam logic [2:0] REG_DEST_IS_ALPHA   = 3'd2;
	localparam logic [2:0] REG_SOURCE_IS_ALPHA = 3'd3;
	localparam logic [2:0] REG_SOURCE_HINT     = 3'd4;
	localparam logic [2:0] REG_DEST_HINT       = 3'd5;
	localparam logic [2:0] REG_ALPHA_HIGH_BYTE = 3'd6;

	// floor(x / 3) for x up to 765 as (x * 683) >> 11
	localparam logic [9:0] LUMA_RECIP = 10'd683;
	localparam int         LUMA_SHIFT = 11;

	typedef enum logic [1:0] {
		KIND_DIRECT,
		KIND_LUMA,
		KIND_BLEND
	} kind_t;

	typedef struct packed {
		logic [1:0] dest_format;
		logic [1:0] source_format;
		logic       dest_is_alpha;
		logic       source_is_alpha;
		logic [1:0] source_hint;
		logic [1:0] dest_hint;
		logic       alpha_high_byte;
	} cfg_t;

	typedef struct packed {
		kind_t           kind;
		logic [31:0]     direct;
		logic [9:0]      luma;
		logic [7:0]      alpha;
		logic [2:0][7:0] s_ch;
		logic [2:0][7:0] d_ch;
		logic            ahb;
	} s1_t;

	typedef struct packed {
		kind_t            kind;
		logic [31:0]      direct;
		logic [19:0]      luma_prod;
		logic [2:0][15:0] d_prod;
		logic [2:0][15:0] s_prod;
		logic             ahb;
	} s2_t;

endpackage
`default_nettype wire

// ===== src/pcb_decode.sv =====
// stage 1: path decode, narrow conversions, channel split
`default_nettype none
module pcb_decode
	import pcb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire cfg_t        cfg,
	input  wire logic [31:0] source_pixel,
	input  wire logic [31:0] dest_pixel,
	output s1_t              data_s1
);

	s1_t  nxt;
	logic [7:0] a;
	logic [1:0] msb_cnt;

	always_comb begin
		nxt        = '0;
		nxt.kind   = KIND_DIRECT;
		nxt.direct = source_pixel;
		nxt.ahb    = cfg.alpha_high_byte;
		nxt.luma   = {2'b0, source_pixel[31:24]} + {2'b0, source_pixel[23:16]}
			+ {2'b0, source_pixel[15:8]};
		msb_cnt    = {1'b0, source_pixel[31]} + {1'b0, source_pixel[23]}
			+ {1'b0, source_pixel[15]};
		if (cfg.alpha_high_byte) begin
			a        = source_pixel[31:24];
			nxt.s_ch = {source_pixel[23:16], source_pixel[15:8], source_pixel[7:0]};
			nxt.d_ch = {dest_pixel[23:16], dest_pixel[15:8], dest_pixel[7:0]};
		end else begin
			a        = source_pixel[7:0];
			nxt.s_ch = {source_pixel[15:8], source_pixel[23:16], source_pixel[31:24]};
			nxt.d_ch = {dest_pixel[15:8], dest_pixel[23:16], dest_pixel[31:24]};
		end
		nxt.alpha = a;

		if (cfg.dest_format == FMT_RESERVED || cfg.source_format == FMT_RESERVED) begin
			nxt.direct = source_pixel;
		end else if (cfg.dest_format != cfg.source_format) begin
			case (cfg.dest_format)
				FMT_1: begin
					if (cfg.source_format == FMT_8 || cfg.dest_is_alpha)
						nxt.direct = {31'b0, source_pixel[7]};
					else
						nxt.direct = {31'b0, msb_cnt[1]};
				end
				FMT_8: begin
					if (cfg.source_format == FMT_1)
						nxt.direct = source_pixel[0] ? 32'h0000_00ff : 32'h0;
					else if (cfg.dest_is_alpha)
						nxt.direct = {24'b0, source_pixel[7:0]};
					else
						nxt.kind = KIND_LUMA;
				end
				default: begin
					if (cfg.source_format == FMT_1) begin
						if (cfg.source_is_alpha)
							nxt.direct = source_pixel[0] ? 32'h0000_00ff : 32'h0;
						else
							nxt.direct = source_pixel[0] ? 32'hffff_ffff : 32'h0000_00ff;
					end else if (cfg.source_is_alpha) begin
						nxt.direct = {24'b0, source_pixel[7:0]};
					end else begin
						nxt.direct = {source_pixel[7:0], source_pixel[7:0],
							source_pixel[7:0], 8'hff};
					end
				end
			endcase
		end else begin
			case (cfg.dest_format)
				FMT_1: nxt.direct = {31'b0, source_pixel[0]};
				FMT_8: nxt.direct = {24'b0, source_pixel[7:0]};
				default: begin
					if (cfg.source_hint == HINT_ZEROALPHA) begin
						nxt.direct = (source_pixel != 32'h0) ? source_pixel : dest_pixel;
					end else if (cfg.source_hint == HINT_OPAQUE
							&& cfg.dest_hint != HINT_OPAQUE) begin
						nxt.direct = source_pixel | (cfg.alpha_high_byte ? 32'hff00_0000
							: 32'h0000_00ff);
					end else if (cfg.source_hint == HINT_OPAQUE) begin
						nxt.direct = source_pixel;
					end else if (a == 8'h00) begin
						nxt.direct = dest_pixel;
					end else if (a == 8'hff) begin
						nxt.direct = source_pixel;
					end else begin
						nxt.kind = KIND_BLEND;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			data_s1 <= nxt;
	end

endmodule
`default_nettype wire

// ===== src/pcb_mix.sv =====
// stage 2: channel weight products and luma reciprocal product
`default_nettype none
module pcb_mix
	import pcb_pkg::*;
(
	input  wire logic clk,
	input  wire logic en,
	input  wire s1_t  data_s1,
	output s2_t       data_s2
);

	s2_t        nxt;
	logic [7:0] inv_a;

	always_comb begin
		inv_a         = 8'hff - data_s1.alpha;
		nxt.kind      = data_s1.kind;
		nxt.direct    = data_s1.direct;
		nxt.ahb       = data_s1.ahb;
		nxt.luma_prod = data_s1.luma * LUMA_RECIP;
		for (int i = 0; i < 3; i++) begin
			nxt.d_prod[i] = data_s1.d_ch[i] * inv_a;
			nxt.s_prod[i] = data_s1.s_ch[i] * data_s1.alpha;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			data_s2 <= nxt;
	end

endmodule
`default_nettype wire

// ===== src/pcb_merge.sv =====
// stage 3: channel sums, luma quotient and result assembly
`default_nettype none
module pcb_merge
	import pcb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire s2_t         data_s2,
	output logic [31:0]      result_s3
);

	logic [2:0][7:0] ch;
	logic [16:0]     sum;
	logic [31:0]     nxt;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum   = {1'b0, data_s2.d_prod[i]} + {1'b0, data_s2.s_prod[i]};
			ch[i] = sum[15:8];
		end
		case (data_s2.kind)
			KIND_LUMA:  nxt = {24'b0, data_s2.luma_prod[LUMA_SHIFT +: 8]};
			KIND_BLEND: begin
				if (data_s2.ahb)
					nxt = {8'hff, ch[2], ch[1], ch[0]};
				else
					nxt = {ch[0], ch[1], ch[2], 8'hff};
			end
			default:    nxt = data_s2.direct;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			result_s3 <= nxt;
	end

endmodule
`default_nettype wire

// ===== src/pixel_convert_blend.sv =====
// pixel_convert_blend: pixel format conversion and 32-bit alpha blend, three stages
// the result passes the decode, mix and merge stage registers on its way to the output
// throughput: one pixel per cycle if not stalled; 8x8 channel products set the stage split
// stalls back up through the valid bits of each stage without loss
// reset: asynchronous, active low; clears valid bits, config goes to 32-bit blend defaults
`default_nettype none
module pixel_convert_blend
	import pcb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // source_pixel [31:0], dest_pixel [63:32]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // result_pixel [31:0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [1:0]  cfg_data
);

	cfg_t        cfg_q;
	logic        valid_s1, valid_s2, valid_s3;
	logic        ready_s1, ready_s2, ready_s3;
	s1_t         data_s1;
	s2_t         data_s2;
	logic [31:0] result_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_format     <= FMT_32;
			cfg_q.source_format   <= FMT_32;
			cfg_q.dest_is_alpha   <= 1'b0;
			cfg_q.source_is_alpha <= 1'b0;
			cfg_q.source_hint     <= HINT_GENERAL;
			cfg_q.dest_hint       <= HINT_GENERAL;
			cfg_q.alpha_high_byte <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEST_FORMAT:     cfg_q.dest_format     <= cfg_data;
				REG_SOURCE_FORMAT:   cfg_q.source_format   <= cfg_data;
				REG_DEST_IS_ALPHA:   cfg_q.dest_is_alpha   <= cfg_data[0];
				REG_SOURCE_IS_ALPHA: cfg_q.source_is_alpha <= cfg_data[0];
				REG_SOURCE_HINT:     cfg_q.source_hint     <= cfg_data;
				REG_DEST_HINT:       cfg_q.dest_hint       <= cfg_data;
				REG_ALPHA_HIGH_BYTE: cfg_q.alpha_high_byte <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or the next one loads
	assign ready_s3      = !valid_s3 || m_axis_tready;
	assign ready_s2      = !valid_s2 || ready_s3;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= s_axis_tvalid;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (ready_s3)
				valid_s3 <= valid_s2;
		end
	end

	pcb_decode u_decode (
		.clk          (clk),
		.en           (ready_s1),
		.cfg          (cfg_q),
		.source_pixel (s_axis_tdata[31:0]),
		.dest_pixel   (s_axis_tdata[63:32]),
		.data_s1      (data_s1)
	);

	pcb_mix u_mix (
		.clk     (clk),
		.en      (ready_s2),
		.data_s1 (data_s1),
		.data_s2 (data_s2)
	);

	pcb_merge u_merge (
		.clk       (clk),
		.en        (ready_s3),
		.data_s2   (data_s2),
		.result_s3 (result_s3)
	);

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = result_s3;

endmodule
`default_nettype wire
